// File: hw/rtl/csa_pkg.sv
// Shared types, codes and field widths of the chunked slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

  // Field widths of the request, result and configuration transactions
  localparam int CHUNK_W  = 4;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Request kinds
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [CHUNK_W-1:0] release_chunk;
    logic [SLOT_W-1:0]  release_slot;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHUNK_W-1:0]  given_chunk;
    logic [SLOT_W-1:0]   given_slot;
    logic                opened_chunk;
  } rsp_t;

  typedef logic [CFG_W-1:0] cfg_t;

  // Action chosen for the current request
  typedef enum logic [2:0] {
    OP_RELEASE = 3'd0,
    OP_POP     = 3'd1,
    OP_FRESH   = 3'd2,
    OP_OPEN    = 3'd3,
    OP_FULL    = 3'd4,
    OP_BAD     = 3'd5
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decide;
    logic apply;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
    logic pop;
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/csa_stream_if.sv
// Valid/ready channel interface with a typed payload.
`timescale 1ns / 1ps
`default_nettype none

interface csa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/chunked_slot_allocator_unit.sv
// Chunked slot allocator: hands out and takes back slots from a pool of chunks.
//
// Channels: req (sink) carries one allocate or release transaction; rsp (source)
// returns exactly one result transaction for each request; cfg (sink) writes
// slots_per_chunk and is always ready.
// Result path: the request is registered at capture, the chosen action at the
// chunk search and the result in the result register; a slot from a chunk's
// free-slot stack also passes through the registered stack RAM read first.
// Flow: a request goes through capture, chunk search (priority encoder over
// the per-chunk room flags) and table update, then the RAM read for a pop;
// the next request is taken only once the result register is loaded.
// Reset: rst (synchronous) closes every chunk, clears all counts and sets
// slots_per_chunk to 64. The stack RAM needs no clearing: an entry is read
// only after it was pushed.
// Stall: a result waiting on rsp does not block the next request being taken;
// its table update waits until the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module chunked_slot_allocator_unit #(
  parameter int MAX_CHUNKS = 16,
  parameter int MAX_SLOTS  = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  csa_stream_if.sink  req,
  csa_stream_if.source rsp,
  csa_stream_if.sink  cfg
);

  csa_pkg::cmd_t  cmd;
  csa_pkg::stat_t stat;

  // Sequencer
  csa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Chunk table, stacks and result register
  csa_datapath #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req_payload (req.payload),
    .cfg_valid   (cfg.valid),
    .cfg_payload (cfg.payload),
    .cfg_ready   (cfg.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

// File: hw/rtl/csa_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/csa_ctrl.sv
// Request sequencer of the chunked slot allocator.
`timescale 1ns / 1ps
`default_nettype none

module csa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire csa_pkg::stat_t stat,
  output csa_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_POP  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Issue commands per state
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.decide = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register can take a new transaction
        if (!stat.out_busy) begin
          cmd.apply = 1'b1;
          if (stat.pop) begin
            state_next = S_POP;
          end else begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      S_POP: begin
        cmd.load_out = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/csa_datapath.sv
// Chunk table, free-slot stacks, chunk search and result register.
`timescale 1ns / 1ps
`default_nettype none

module csa_datapath #(
  parameter int MAX_CHUNKS = 16,
  parameter int MAX_SLOTS  = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire csa_pkg::req_t  req_payload,
  input  wire logic           cfg_valid,
  input  wire csa_pkg::cfg_t  cfg_payload,
  output logic                cfg_ready,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output csa_pkg::rsp_t       rsp_payload,
  input  wire csa_pkg::cmd_t  cmd,
  output csa_pkg::stat_t      stat
);

  localparam int CW        = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int OW        = $clog2(MAX_CHUNKS + 1);
  localparam int LW        = $clog2(MAX_SLOTS + 1);
  localparam int EW        = (LW > csa_pkg::CFG_W) ? LW : csa_pkg::CFG_W;
  localparam int RW        = (OW > csa_pkg::CHUNK_W) ? OW : csa_pkg::CHUNK_W;
  localparam int MEM_DEPTH = MAX_CHUNKS * MAX_SLOTS;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  csa_pkg::cfg_t  slots_per_chunk;
  csa_pkg::req_t  rq;
  logic [OW-1:0]  chunks_open;
  logic [LW-1:0]  live [MAX_CHUNKS];
  logic [LW-1:0]  depth [MAX_CHUNKS];
  csa_pkg::op_t   op;
  logic [CW-1:0]  sel;

  logic [EW-1:0]  eff_wide;
  logic [LW-1:0]  eff;
  logic [MAX_CHUNKS-1:0] room;
  logic           found;
  logic [CW-1:0]  found_idx;
  logic [CW-1:0]  rc_idx;
  logic           rel_ok;
  csa_pkg::op_t   op_next;
  logic [CW-1:0]  sel_next;
  logic [LW-1:0]  live_sel;
  logic [LW-1:0]  dep_sel;
  logic [AW-1:0]  mem_addr;
  logic           mem_we;
  logic [csa_pkg::SLOT_W-1:0] mem_rdata;
  csa_pkg::rsp_t  res;

  // Configuration register: always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_chunk <= csa_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      slots_per_chunk <= cfg_payload;
    end
  end

  // Clamp the slot count to 1..MAX_SLOTS
  always_comb begin
    if (slots_per_chunk == '0) begin
      eff_wide = EW'(1);
    end else if (EW'(slots_per_chunk) > EW'(MAX_SLOTS)) begin
      eff_wide = EW'(MAX_SLOTS);
    end else begin
      eff_wide = EW'(slots_per_chunk);
    end
  end
  assign eff = eff_wide[LW-1:0];

  // Capture the request transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq <= req_payload;
    end
  end

  // Per-chunk room flags
  always_comb begin
    for (int c = 0; c < MAX_CHUNKS; c++) begin
      room[c] = (OW'(c) < chunks_open) && ((depth[c] != '0) || (live[c] < eff));
    end
  end

  // Priority encoder: lowest open chunk with room
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int c = MAX_CHUNKS - 1; c >= 0; c--) begin
      if (room[c]) begin
        found     = 1'b1;
        found_idx = CW'(c);
      end
    end
  end

  // Release check: chunk open and not empty
  assign rc_idx = CW'(rq.release_chunk);
  assign rel_ok = (RW'(rq.release_chunk) < RW'(chunks_open)) && (live[rc_idx] != '0);

  // Pick the action for the request
  always_comb begin
    op_next  = csa_pkg::OP_FULL;
    sel_next = '0;
    if (rq.req_type == csa_pkg::REQ_RELEASE) begin
      op_next  = rel_ok ? csa_pkg::OP_RELEASE : csa_pkg::OP_BAD;
      sel_next = rc_idx;
    end else if (found) begin
      op_next  = (depth[found_idx] != '0) ? csa_pkg::OP_POP : csa_pkg::OP_FRESH;
      sel_next = found_idx;
    end else if (chunks_open != OW'(MAX_CHUNKS)) begin
      op_next  = csa_pkg::OP_OPEN;
      sel_next = CW'(chunks_open);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      op  <= op_next;
      sel <= sel_next;
    end
  end

  // Stack address: top entry for a pop, next free entry for a push
  assign live_sel = live[sel];
  assign dep_sel  = depth[sel];
  assign mem_addr = AW'(AW'(sel) * AW'(MAX_SLOTS) + AW'(dep_sel)
                        - ((op == csa_pkg::OP_POP) ? AW'(1) : AW'(0)));
  assign mem_we   = cmd.apply && (op == csa_pkg::OP_RELEASE) && (dep_sel < LW'(MAX_SLOTS));

  csa_ram #(
    .WIDTH (csa_pkg::SLOT_W),
    .DEPTH (MEM_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (rq.release_slot),
    .rdata (mem_rdata)
  );

  // Update the chunk table
  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_open <= '0;
      for (int c = 0; c < MAX_CHUNKS; c++) begin
        live[c]  <= '0;
        depth[c] <= '0;
      end
    end else if (cmd.apply) begin
      case (op)
        csa_pkg::OP_RELEASE: begin
          live[sel] <= live_sel - LW'(1);
          // last live slot gone: drop the whole stack
          if (live_sel == LW'(1)) begin
            depth[sel] <= '0;
          end else if (dep_sel < LW'(MAX_SLOTS)) begin
            depth[sel] <= dep_sel + LW'(1);
          end
        end
        csa_pkg::OP_POP: begin
          depth[sel] <= dep_sel - LW'(1);
          live[sel]  <= live_sel + LW'(1);
        end
        csa_pkg::OP_FRESH: begin
          live[sel] <= live_sel + LW'(1);
        end
        csa_pkg::OP_OPEN: begin
          chunks_open <= chunks_open + OW'(1);
          live[sel]   <= LW'(1);
          depth[sel]  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Build the result transaction
  always_comb begin
    res = '0;
    case (op)
      csa_pkg::OP_FULL: res.status = csa_pkg::STATUS_FULL;
      csa_pkg::OP_BAD:  res.status = csa_pkg::STATUS_BAD_RELEASE;
      default:          res.status = csa_pkg::STATUS_OK;
    endcase
    if (op == csa_pkg::OP_POP || op == csa_pkg::OP_FRESH || op == csa_pkg::OP_OPEN) begin
      res.given_chunk = csa_pkg::CHUNK_W'(sel);
    end
    if (op == csa_pkg::OP_POP) begin
      res.given_slot = mem_rdata;
    end else if (op == csa_pkg::OP_FRESH) begin
      res.given_slot = csa_pkg::SLOT_W'(live_sel);
    end
    res.opened_chunk = (op == csa_pkg::OP_OPEN);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_payload <= res;
    end
  end

  assign stat.out_busy = rsp_valid && !rsp_ready;
  assign stat.pop      = (op == csa_pkg::OP_POP);

endmodule

`default_nettype wire

// File: hw/rtl/csa_checker.sv
// Port-level assertions for the chunked slot allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module csa_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire csa_pkg::rsp_t rsp_payload
);

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // One request at a time: no transaction right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one in progress");

  // Failed results carry a failure status and no chunk, slot or open flag
  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_payload.status != csa_pkg::STATUS_OK) |->
    ((rsp_payload.status == csa_pkg::STATUS_FULL ||
      rsp_payload.status == csa_pkg::STATUS_BAD_RELEASE) &&
     rsp_payload.given_chunk == '0 && rsp_payload.given_slot == '0 &&
     !rsp_payload.opened_chunk))
    else $error("bad status or nonzero fields on failed result");

  // A freshly opened chunk hands out slot zero
  a_open_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_payload.opened_chunk) |-> (rsp_payload.given_slot == '0))
    else $error("opened chunk gave nonzero slot");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
    else $error("stalled result changed");

endmodule

bind chunked_slot_allocator_unit csa_checker u_csa_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

`default_nettype wire

// File: tb/chunked_slot_allocator_unit_tb.sv
// Self-checking testbench for the chunked slot allocator: driver, monitor and pool predictor.
`timescale 1ns / 1ps

module chunked_slot_allocator_unit_tb;

  localparam int NUM_CHUNKS = 16;
  localparam int SLOTS_MAX  = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  // Two copies of the pool: one runs ahead while requests are planned,
  // the other follows the transactions that the block actually accepts.
  localparam int PLAN_POOL  = 0;
  localparam int CHECK_POOL = 1;

  logic clk;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  csa_pkg::req_t req_data  = '0;
  logic rsp_ready = 1'b0;
  logic cfg_valid = 1'b0;
  csa_pkg::cfg_t cfg_data  = '0;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  csa_stream_if #(.payload_t(csa_pkg::req_t)) req_ch ();
  csa_stream_if #(.payload_t(csa_pkg::rsp_t)) rsp_ch ();
  csa_stream_if #(.payload_t(csa_pkg::cfg_t)) cfg_ch ();

  assign req_ch.valid   = req_valid;
  assign req_ch.payload = req_data;
  assign rsp_ch.ready   = rsp_ready;
  assign cfg_ch.valid   = cfg_valid;
  assign cfg_ch.payload = cfg_data;

  chunked_slot_allocator_unit #(
    .MAX_CHUNKS(NUM_CHUNKS),
    .MAX_SLOTS (SLOTS_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Pool state, one copy per pool index
  csa_pkg::cfg_t slots_cfg [2];
  logic [4:0] chunks_open [2];
  logic [6:0] live_count  [2][NUM_CHUNKS];
  logic [6:0] stack_depth [2][NUM_CHUNKS];
  logic [5:0] freed_slots [2][NUM_CHUNKS][SLOTS_MAX];

  csa_pkg::req_t request_backlog[$];
  csa_pkg::rsp_t awaited_results[$];
  logic [9:0] held_slots[$];

  int mismatches = 0;
  int results_seen = 0;
  int full_seen = 0;
  int rejects_seen = 0;
  int openings_seen = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Close every chunk and restore the reset slot count
  function automatic void clear_pool(input int m);
    slots_cfg[m] = csa_pkg::CFG_RESET;
    chunks_open[m] = '0;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      live_count[m][c] = '0;
      stack_depth[m][c] = '0;
    end
  endfunction

  // Apply one request to pool m and return the result it must produce
  function automatic csa_pkg::rsp_t serve_request(input int m, input csa_pkg::req_t r);
    csa_pkg::rsp_t res;
    int eff;
    int c;
    bit placed;
    res = '0;
    res.status = csa_pkg::STATUS_OK;
    eff = int'(slots_cfg[m]);
    if (eff == 0) eff = 1;
    if (eff > SLOTS_MAX) eff = SLOTS_MAX;
    c = int'(r.release_chunk);
    if (r.req_type == csa_pkg::REQ_RELEASE) begin
      if (c >= int'(chunks_open[m]) || live_count[m][c] == 0) begin
        res.status = csa_pkg::STATUS_BAD_RELEASE;
      end else begin
        if (stack_depth[m][c] < SLOTS_MAX) begin
          freed_slots[m][c][stack_depth[m][c]] = r.release_slot;
          stack_depth[m][c] = stack_depth[m][c] + 7'd1;
        end
        live_count[m][c] = live_count[m][c] - 7'd1;
        // a chunk that empties drops its recycled slots
        if (live_count[m][c] == 0) stack_depth[m][c] = '0;
      end
      return res;
    end
    // First open chunk with a recycled slot or room for a fresh one
    placed = 1'b0;
    for (c = 0; c < int'(chunks_open[m]) && !placed; c++) begin
      if (stack_depth[m][c] != 0) begin
        stack_depth[m][c] = stack_depth[m][c] - 7'd1;
        res.given_chunk = c[3:0];
        res.given_slot = freed_slots[m][c][stack_depth[m][c]];
        live_count[m][c] = live_count[m][c] + 7'd1;
        placed = 1'b1;
      end else if (int'(live_count[m][c]) < eff) begin
        res.given_chunk = c[3:0];
        res.given_slot = live_count[m][c][5:0];
        live_count[m][c] = live_count[m][c] + 7'd1;
        placed = 1'b1;
      end
    end
    if (!placed) begin
      if (int'(chunks_open[m]) >= NUM_CHUNKS) begin
        res.status = csa_pkg::STATUS_FULL;
      end else begin
        c = int'(chunks_open[m]);
        chunks_open[m] = chunks_open[m] + 5'd1;
        live_count[m][c] = 7'd1;
        stack_depth[m][c] = '0;
        res.given_chunk = c[3:0];
        res.opened_chunk = 1'b1;
      end
    end
    return res;
  endfunction

  // Queue a request and track the slots it hands out
  task automatic plan_request(input csa_pkg::req_t r);
    csa_pkg::rsp_t res;
    res = serve_request(PLAN_POOL, r);
    if (r.req_type == csa_pkg::REQ_ALLOC && res.status == csa_pkg::STATUS_OK)
      held_slots = {held_slots, {res.given_chunk, res.given_slot}};
    request_backlog = {request_backlog, r};
  endtask

  task automatic plan_op(input logic kind, input int chunk, input int slot);
    csa_pkg::req_t r;
    r.req_type = kind;
    r.release_chunk = chunk[3:0];
    r.release_slot = slot[5:0];
    plan_request(r);
  endtask

  // Allocations and releases of held slots; a few stray releases
  task automatic plan_random(input int release_pct);
    csa_pkg::req_t r;
    int roll;
    int k;
    roll = $urandom_range(99);
    r.req_type = csa_pkg::REQ_ALLOC;
    r.release_chunk = 4'($urandom_range(NUM_CHUNKS - 1));
    r.release_slot = 6'($urandom_range(SLOTS_MAX - 1));
    if (roll < 8) begin
      r.req_type = csa_pkg::REQ_RELEASE;
    end else if (roll < 8 + release_pct && held_slots.size() != 0) begin
      k = $urandom_range(held_slots.size() - 1);
      r.req_type = csa_pkg::REQ_RELEASE;
      {r.release_chunk, r.release_slot} = held_slots[k];
      held_slots.delete(k);
    end
    plan_request(r);
  endtask

  task automatic wait_drained();
    while (request_backlog.size() != 0 || req_valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  // Drain, write the slot count while idle, then set the idle pattern
  task automatic open_phase(input csa_pkg::cfg_t slots, input int src_pct, input int snk_pct);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= slots;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_valid <= 1'b0;
    slots_cfg[PLAN_POOL] = slots;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    @(negedge clk);
  endtask

  // Request driver: advance to the next queued transaction once accepted
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ch.ready) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        req_valid <= 1'b1;
        req_data <= request_backlog.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result sink: stall at random
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Monitor: follow config and requests, compare each result with the oldest expectation
  always @(posedge clk) begin : score_results
    csa_pkg::rsp_t want;
    csa_pkg::rsp_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ch.ready) slots_cfg[CHECK_POOL] = cfg_data;
      if (rsp_ch.valid && rsp_ready) begin
        got = rsp_ch.payload;
        results_seen++;
        if (got.status == csa_pkg::STATUS_FULL) full_seen++;
        if (got.status == csa_pkg::STATUS_BAD_RELEASE) rejects_seen++;
        if (got.opened_chunk) openings_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing outstanding: status=%0d chunk=%0d slot=%0d",
                     $realtime, got.status, got.given_chunk, got.given_slot);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.given_chunk !== want.given_chunk ||
              got.given_slot !== want.given_slot ||
              got.opened_chunk !== want.opened_chunk) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: expected status=%0d chunk=%0d slot=%0d opened=%0d, %s%0d %s%0d %s%0d %s%0d",
                       $realtime, want.status, want.given_chunk, want.given_slot,
                       want.opened_chunk, "got status=", got.status, "chunk=",
                       got.given_chunk, "slot=", got.given_slot, "opened=",
                       got.opened_chunk);
          end
        end
      end
      if (req_valid && req_ch.ready)
        awaited_results = {awaited_results, serve_request(CHECK_POOL, req_data)};
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready) ||
          (cfg_valid && cfg_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    clear_pool(PLAN_POOL);
    clear_pool(CHECK_POOL);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // One slot per chunk: stray release, open all chunks, hit pool full,
    // empty a chunk, release it twice, then reuse it
    open_phase(7'd1, 0, 0);
    plan_op(csa_pkg::REQ_RELEASE, 0, 63);
    repeat (NUM_CHUNKS + 1) plan_op(csa_pkg::REQ_ALLOC, 0, 0);
    plan_op(csa_pkg::REQ_RELEASE, 3, 0);
    plan_op(csa_pkg::REQ_RELEASE, 3, 0);
    plan_op(csa_pkg::REQ_ALLOC, 15, 63);

    // Above the slot maximum: fresh slots, LIFO pops, a slot never handed out recycled
    open_phase(7'd127, 0, 0);
    plan_op(csa_pkg::REQ_ALLOC, 0, 0);
    plan_op(csa_pkg::REQ_ALLOC, 0, 0);
    plan_op(csa_pkg::REQ_RELEASE, 0, 2);
    plan_op(csa_pkg::REQ_RELEASE, 0, 1);
    plan_op(csa_pkg::REQ_ALLOC, 0, 0);
    plan_op(csa_pkg::REQ_ALLOC, 0, 0);
    plan_op(csa_pkg::REQ_RELEASE, 0, 63);
    plan_op(csa_pkg::REQ_ALLOC, 0, 0);
    repeat (250) plan_random(40);

    open_phase(7'd0, 75, 0);
    repeat (250) plan_random(40);

    open_phase(7'd5, 0, 75);
    repeat (300) plan_random(45);

    open_phase(7'd64, 15, 15);
    repeat (300) plan_random(35);

    open_phase(7'd2, 0, 0);
    repeat (300) plan_random(45);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results over six slot-count settings and four idle patterns:",
             results_seen);
    $display("  %0d chunk openings, %0d pool-full answers, %0d rejected releases.",
             openings_seen, full_seen, rejects_seen);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/csa_pkg.sv
hw/rtl/csa_stream_if.sv
hw/rtl/csa_ram.sv
hw/rtl/csa_ctrl.sv
hw/rtl/csa_datapath.sv
hw/rtl/chunked_slot_allocator_unit.sv
hw/rtl/csa_checker.sv
tb/chunked_slot_allocator_unit_tb.sv
